[rtl/arp_neighbor_resolver_defines.svh]
// Assertion macros for the ARP neighbour resolver.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ARP_NEIGHBOR_RESOLVER_DEFINES_SVH
`define ARP_NEIGHBOR_RESOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define ANR_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ANR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ANR_ASSERT(lbl, ante, cons)
`define ANR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/anr_pkg.sv]
// Shared types and constants for the ARP neighbour resolver.
// No dependencies.
`default_nettype none
package anr_pkg;
    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;
    localparam int HANDLE_W = 8;
    localparam int TIME_W   = 48;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [MS_W-1:0]  LIFETIME_RESET = 16'd30000;
    localparam logic [MS_W-1:0]  HOLDOFF_RESET  = 16'd5000;
    localparam logic [MAC_W-1:0] BCAST_MAC      = {MAC_W{1'b1}};

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RECV = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] FT_IPV4  = 2'd0;
    localparam logic [1:0] FT_ARP   = 2'd1;
    localparam logic [1:0] FT_OTHER = 2'd2;
    localparam logic [1:0] FT_UNDEF = 2'd3;

    localparam logic [1:0] ARP_OP_OTHER   = 2'd0;
    localparam logic [1:0] ARP_OP_REQUEST = 2'd1;
    localparam logic [1:0] ARP_OP_REPLY   = 2'd2;
    localparam logic [1:0] ARP_OP_UNDEF   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 2'd3;

    typedef enum logic [2:0] {
        KIND_IPV4      = 3'd0,
        KIND_ARP_REQ   = 3'd1,
        KIND_ARP_REPLY = 3'd2,
        KIND_DELIVER   = 3'd3,
        KIND_DROP      = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_FWD_HIT,
        RES_DROP,
        RES_REQ,
        RES_REPLY,
        RES_DELIVER,
        RES_FWD_PEND
    } res_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SEND_RES,
        ST_SEND_REQ,
        ST_LEARN,
        ST_PEND_RD,
        ST_PEND_CMP,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [IP_W-1:0]     hop_ip;
        logic [HANDLE_W-1:0] datagram_handle;
        logic [MAC_W-1:0]    frame_dst_mac;
        logic [1:0]          frame_type;
        logic                parse_ok;
        logic [1:0]          arp_opcode;
        logic [IP_W-1:0]     sender_ip;
        logic [MAC_W-1:0]    sender_mac;
        logic [IP_W-1:0]     target_ip;
        logic [MS_W-1:0]     elapsed_ms;
    } in_item_t;

    typedef struct packed {
        kind_t               kind;
        logic [MAC_W-1:0]    dst_mac;
        logic [IP_W-1:0]     arp_target_ip;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } cache_ent_t;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] stamp;
    } hold_ent_t;

    typedef struct packed {
        logic [IP_W-1:0]     ip;
        logic [HANDLE_W-1:0] handle;
    } pend_ent_t;

    typedef struct packed {
        logic     accept;
        logic     scan_start;
        logic     scan_step;
        logic     queue_push;
        logic     hold_write;
        logic     cache_write;
        logic     pend_start;
        logic     pend_step;
        logic     flush;
        res_sel_t res_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       rx_pass;
        logic [1:0] frame_type;
        logic       scan_last;
        logic       cache_hit;
        logic       hold_hit;
        logic       queue_full;
        logic       queue_empty;
        logic       pend_last;
        logic       pend_match;
        logic       reply_due;
    } dp_status_t;
endpackage
`default_nettype wire

[rtl/anr_ctrl.sv]
// Sequencer for the ARP neighbour resolver.
// Depends on anr_pkg; drives anr_datapath through ctl_cmd_t.
`default_nettype none
module anr_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  anr_pkg::dp_status_t st,
    output anr_pkg::ctl_cmd_t ctl
);
    anr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= anr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            anr_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = anr_pkg::ST_DISPATCH;
            end
            anr_pkg::ST_DISPATCH:
            begin
                if (st.cmd == anr_pkg::CMD_SEND || st.cmd == anr_pkg::CMD_TICK)
                    state_next = anr_pkg::ST_SCAN_RD;
                else if (st.cmd == anr_pkg::CMD_RECV && st.rx_pass
                         && st.frame_type == anr_pkg::FT_ARP)
                    state_next = anr_pkg::ST_SCAN_RD;
                else
                    state_next = anr_pkg::ST_FLUSH;
            end
            anr_pkg::ST_SCAN_RD:
                state_next = anr_pkg::ST_SCAN_CMP;
            anr_pkg::ST_SCAN_CMP:
            begin
                if (!st.scan_last)
                    state_next = anr_pkg::ST_SCAN_RD;
                else if (st.cmd == anr_pkg::CMD_SEND)
                    state_next = anr_pkg::ST_SEND_RES;
                else if (st.cmd == anr_pkg::CMD_RECV)
                    state_next = anr_pkg::ST_LEARN;
                else
                    state_next = anr_pkg::ST_FLUSH;
            end
            anr_pkg::ST_SEND_RES:
                state_next = st.cache_hit ? anr_pkg::ST_FLUSH : anr_pkg::ST_SEND_REQ;
            anr_pkg::ST_SEND_REQ:
                state_next = anr_pkg::ST_FLUSH;
            anr_pkg::ST_LEARN:
                state_next = st.queue_empty ? anr_pkg::ST_FLUSH : anr_pkg::ST_PEND_RD;
            anr_pkg::ST_PEND_RD:
                state_next = anr_pkg::ST_PEND_CMP;
            anr_pkg::ST_PEND_CMP:
                state_next = st.pend_last ? anr_pkg::ST_FLUSH : anr_pkg::ST_PEND_RD;
            anr_pkg::ST_FLUSH:
                state_next = anr_pkg::ST_IDLE;
            default:
                state_next = anr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ctl.res_sel = anr_pkg::RES_NONE;
        busy        = (state_reg != anr_pkg::ST_IDLE);
        unique case (state_reg)
            anr_pkg::ST_IDLE:
                ctl.accept = start;
            anr_pkg::ST_DISPATCH:
            begin
                ctl.scan_start = 1'b1;
                if (st.cmd == anr_pkg::CMD_RECV && st.rx_pass
                    && st.frame_type == anr_pkg::FT_IPV4)
                    ctl.res_sel = anr_pkg::RES_DELIVER;
            end
            anr_pkg::ST_SCAN_RD:
                ctl = ctl;
            anr_pkg::ST_SCAN_CMP:
                ctl.scan_step = 1'b1;
            anr_pkg::ST_SEND_RES:
            begin
                if (st.cache_hit)
                    ctl.res_sel = anr_pkg::RES_FWD_HIT;
                else if (st.queue_full)
                    ctl.res_sel = anr_pkg::RES_DROP;
                else
                    ctl.queue_push = 1'b1;
            end
            anr_pkg::ST_SEND_REQ:
            begin
                if (!st.hold_hit)
                begin
                    ctl.res_sel    = anr_pkg::RES_REQ;
                    ctl.hold_write = 1'b1;
                end
            end
            anr_pkg::ST_LEARN:
            begin
                ctl.cache_write = 1'b1;
                ctl.pend_start  = 1'b1;
                if (st.reply_due)
                    ctl.res_sel = anr_pkg::RES_REPLY;
            end
            anr_pkg::ST_PEND_RD:
                ctl = ctl;
            anr_pkg::ST_PEND_CMP:
            begin
                ctl.pend_step = 1'b1;
                if (st.pend_match)
                    ctl.res_sel = anr_pkg::RES_FWD_PEND;
            end
            anr_pkg::ST_FLUSH:
                ctl.flush = 1'b1;
            default:
                ctl = ctl;
        endcase
    end
endmodule
`default_nettype wire

[rtl/anr_datapath.sv]
// Tables, pending queue, config registers and result staging.
// Depends on anr_pkg; commanded by anr_ctrl.
`default_nettype none
module anr_datapath #(
    parameter int C = 16,
    parameter int H = 16,
    parameter int P = 32
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  anr_pkg::in_item_t                 item,
    input  wire                               cfg_we,
    input  wire [anr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [anr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  anr_pkg::ctl_cmd_t                 ctl,
    output anr_pkg::dp_status_t               st,
    output logic                              result_valid,
    output anr_pkg::out_item_t                result
);
    localparam int CAW    = (C > 1) ? $clog2(C) : 1;
    localparam int HAW    = (H > 1) ? $clog2(H) : 1;
    localparam int PAW    = (P > 1) ? $clog2(P) : 1;
    localparam int SCAN_N = (C > H) ? C : H;
    localparam int MAXN   = (SCAN_N > P) ? SCAN_N : P;
    localparam int IW     = $clog2(MAXN + 1);
    localparam int CNT_W  = $clog2(P + 1);
    localparam int TW     = anr_pkg::TIME_W;

    anr_pkg::in_item_t item_reg;
    logic [anr_pkg::MAC_W-1:0] own_mac_reg;
    logic [anr_pkg::IP_W-1:0]  own_ip_reg;
    logic [anr_pkg::MS_W-1:0]  life_reg, hold_ms_reg;
    logic [TW-1:0] now_reg, now_next;

    logic [C-1:0] cache_valid_reg, cache_valid_next;
    logic [H-1:0] hold_valid_reg, hold_valid_next;
    anr_pkg::cache_ent_t cache_mem [C];
    anr_pkg::hold_ent_t  hold_mem [H];
    anr_pkg::pend_ent_t  pend_mem [P];
    anr_pkg::cache_ent_t cache_rd_reg;
    anr_pkg::hold_ent_t  hold_rd_reg;
    anr_pkg::pend_ent_t  pend_rd_reg;

    logic [IW-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0] jdx_reg, jdx_next, count_reg, count_next;

    // scan trackers: matching entry, first free, oldest valid
    logic           c_hit_v_reg, c_hit_v_next, c_free_v_reg, c_free_v_next;
    logic           c_old_v_reg, c_old_v_next;
    logic [CAW-1:0] c_hit_idx_reg, c_hit_idx_next, c_free_idx_reg, c_free_idx_next;
    logic [CAW-1:0] c_old_idx_reg, c_old_idx_next;
    logic [TW-1:0]  c_old_age_reg, c_old_age_next;
    logic [anr_pkg::MAC_W-1:0] c_hit_mac_reg, c_hit_mac_next;
    logic           h_hit_v_reg, h_hit_v_next, h_free_v_reg, h_free_v_next;
    logic           h_old_v_reg, h_old_v_next;
    logic [HAW-1:0] h_free_idx_reg, h_free_idx_next, h_old_idx_reg, h_old_idx_next;
    logic [TW-1:0]  h_old_age_reg, h_old_age_next;

    anr_pkg::out_item_t hold_res_reg, hold_res_next, out_reg, out_next, new_res;
    logic               hold_v_reg, hold_v_next, out_v_reg, out_v_next;

    logic [CAW-1:0] c_a, c_slot;
    logic [HAW-1:0] h_a, h_slot;
    logic           c_in, h_in, c_valid, h_valid, c_match, h_match;
    logic [TW-1:0]  c_age, h_age;
    logic [anr_pkg::IP_W-1:0] key_ip;
    logic [PAW-1:0] p_wa;
    anr_pkg::pend_ent_t p_wd;
    logic           p_we;

    assign c_a     = idx_reg[CAW-1:0];
    assign h_a     = idx_reg[HAW-1:0];
    assign c_in    = idx_reg < IW'(C);
    assign h_in    = idx_reg < IW'(H);
    assign c_valid = cache_valid_reg[c_a];
    assign h_valid = hold_valid_reg[h_a];
    assign c_age   = now_reg - cache_rd_reg.stamp;
    assign h_age   = now_reg - hold_rd_reg.stamp;
    assign key_ip  = (item_reg.cmd == anr_pkg::CMD_SEND) ? item_reg.hop_ip
                                                         : item_reg.sender_ip;
    assign c_match = c_in && c_valid && (cache_rd_reg.ip == key_ip);
    assign h_match = h_in && h_valid && (hold_rd_reg.ip == item_reg.hop_ip);
    assign c_slot  = c_hit_v_reg ? c_hit_idx_reg
                                 : (c_free_v_reg ? c_free_idx_reg : c_old_idx_reg);
    assign h_slot  = h_free_v_reg ? h_free_idx_reg : h_old_idx_reg;

    always_comb
    begin
        st.cmd         = item_reg.cmd;
        st.rx_pass     = ((item_reg.frame_dst_mac == own_mac_reg)
                          || (item_reg.frame_dst_mac == anr_pkg::BCAST_MAC))
                         && item_reg.parse_ok;
        st.frame_type  = item_reg.frame_type;
        st.scan_last   = (idx_reg == IW'(SCAN_N - 1));
        st.cache_hit   = c_hit_v_reg;
        st.hold_hit    = h_hit_v_reg;
        st.queue_full  = (count_reg == CNT_W'(P));
        st.queue_empty = (count_reg == '0);
        st.pend_last   = ((idx_reg + IW'(1)) == IW'(count_reg));
        st.pend_match  = (pend_rd_reg.ip == item_reg.sender_ip);
        st.reply_due   = (item_reg.arp_opcode == anr_pkg::ARP_OP_REQUEST)
                         && (item_reg.target_ip == own_ip_reg);
    end

    // scan, expiry, counters
    always_comb
    begin
        now_next         = now_reg;
        cache_valid_next = cache_valid_reg;
        hold_valid_next  = hold_valid_reg;
        idx_next         = idx_reg;
        jdx_next         = jdx_reg;
        count_next       = count_reg;
        c_hit_v_next     = c_hit_v_reg;   c_hit_idx_next  = c_hit_idx_reg;
        c_free_v_next    = c_free_v_reg;  c_free_idx_next = c_free_idx_reg;
        c_old_v_next     = c_old_v_reg;   c_old_idx_next  = c_old_idx_reg;
        c_old_age_next   = c_old_age_reg; c_hit_mac_next  = c_hit_mac_reg;
        h_hit_v_next     = h_hit_v_reg;
        h_free_v_next    = h_free_v_reg;  h_free_idx_next = h_free_idx_reg;
        h_old_v_next     = h_old_v_reg;   h_old_idx_next  = h_old_idx_reg;
        h_old_age_next   = h_old_age_reg;
        p_we             = 1'b0;
        p_wa             = jdx_reg[PAW-1:0];
        p_wd             = pend_rd_reg;

        if (ctl.accept && item.cmd == anr_pkg::CMD_TICK)
            now_next = now_reg + {{(TW-anr_pkg::MS_W){1'b0}}, item.elapsed_ms};

        if (ctl.scan_start)
        begin
            idx_next      = '0;
            c_hit_v_next  = 1'b0;
            c_free_v_next = 1'b0;
            c_old_v_next  = 1'b0;
            h_hit_v_next  = 1'b0;
            h_free_v_next = 1'b0;
            h_old_v_next  = 1'b0;
        end

        if (ctl.scan_step)
        begin
            idx_next = idx_reg + IW'(1);
            if (c_in)
            begin
                if (c_match && !c_hit_v_reg)
                begin
                    c_hit_v_next   = 1'b1;
                    c_hit_idx_next = c_a;
                    c_hit_mac_next = cache_rd_reg.mac;
                end
                if (!c_valid && !c_free_v_reg)
                begin
                    c_free_v_next   = 1'b1;
                    c_free_idx_next = c_a;
                end
                if (c_valid && (!c_old_v_reg || c_age > c_old_age_reg))
                begin
                    c_old_v_next   = 1'b1;
                    c_old_idx_next = c_a;
                    c_old_age_next = c_age;
                end
                if (item_reg.cmd == anr_pkg::CMD_TICK && c_valid
                    && c_age >= {{(TW-anr_pkg::MS_W){1'b0}}, life_reg})
                    cache_valid_next[c_a] = 1'b0;
            end
            if (h_in)
            begin
                if (h_match)
                    h_hit_v_next = 1'b1;
                if (!h_valid && !h_free_v_reg)
                begin
                    h_free_v_next   = 1'b1;
                    h_free_idx_next = h_a;
                end
                if (h_valid && (!h_old_v_reg || h_age > h_old_age_reg))
                begin
                    h_old_v_next   = 1'b1;
                    h_old_idx_next = h_a;
                    h_old_age_next = h_age;
                end
                if (item_reg.cmd == anr_pkg::CMD_TICK && h_valid
                    && h_age >= {{(TW-anr_pkg::MS_W){1'b0}}, hold_ms_reg})
                    hold_valid_next[h_a] = 1'b0;
            end
        end

        if (ctl.cache_write)
            cache_valid_next[c_slot] = 1'b1;
        if (ctl.hold_write)
            hold_valid_next[h_slot] = 1'b1;

        if (ctl.queue_push)
        begin
            p_we       = 1'b1;
            p_wa       = count_reg[PAW-1:0];
            p_wd.ip    = item_reg.hop_ip;
            p_wd.handle = item_reg.datagram_handle;
            count_next = count_reg + CNT_W'(1);
        end

        if (ctl.pend_start)
        begin
            idx_next = '0;
            jdx_next = '0;
        end

        // compaction: survivors move down to the write pointer
        if (ctl.pend_step)
        begin
            idx_next = idx_reg + IW'(1);
            if (!st.pend_match)
            begin
                p_we     = 1'b1;
                jdx_next = jdx_reg + CNT_W'(1);
            end
            if (st.pend_last)
                count_next = jdx_next;
        end
    end

    // result staging: one result is held back so the final one can carry last
    always_comb
    begin
        new_res               = '0;
        new_res.kind          = anr_pkg::KIND_IPV4;
        new_res.handle        = item_reg.datagram_handle;
        case (ctl.res_sel)
            anr_pkg::RES_FWD_HIT:
                new_res.dst_mac = c_hit_mac_reg;
            anr_pkg::RES_DROP:
                new_res.kind = anr_pkg::KIND_DROP;
            anr_pkg::RES_REQ:
            begin
                new_res.kind          = anr_pkg::KIND_ARP_REQ;
                new_res.dst_mac       = anr_pkg::BCAST_MAC;
                new_res.arp_target_ip = item_reg.hop_ip;
                new_res.handle        = '0;
            end
            anr_pkg::RES_REPLY:
            begin
                new_res.kind          = anr_pkg::KIND_ARP_REPLY;
                new_res.dst_mac       = item_reg.sender_mac;
                new_res.arp_target_ip = item_reg.sender_ip;
                new_res.handle        = '0;
            end
            anr_pkg::RES_DELIVER:
                new_res.kind = anr_pkg::KIND_DELIVER;
            anr_pkg::RES_FWD_PEND:
            begin
                new_res.dst_mac = item_reg.sender_mac;
                new_res.handle  = pend_rd_reg.handle;
            end
            default:
                new_res = new_res;
        endcase

        hold_res_next = hold_res_reg;
        hold_v_next   = hold_v_reg;
        out_next      = hold_res_reg;
        out_v_next    = 1'b0;
        if (ctl.res_sel != anr_pkg::RES_NONE)
        begin
            hold_res_next = new_res;
            hold_v_next   = 1'b1;
            out_v_next    = hold_v_reg;
        end
        else if (ctl.flush && hold_v_reg)
        begin
            out_next.last = 1'b1;
            out_v_next    = 1'b1;
            hold_v_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg     <= '0;
            own_ip_reg      <= '0;
            life_reg        <= anr_pkg::LIFETIME_RESET;
            hold_ms_reg     <= anr_pkg::HOLDOFF_RESET;
            now_reg         <= '0;
            cache_valid_reg <= '0;
            hold_valid_reg  <= '0;
            idx_reg         <= '0;
            jdx_reg         <= '0;
            count_reg       <= '0;
            c_hit_v_reg     <= 1'b0;
            c_free_v_reg    <= 1'b0;
            c_old_v_reg     <= 1'b0;
            h_hit_v_reg     <= 1'b0;
            h_free_v_reg    <= 1'b0;
            h_old_v_reg     <= 1'b0;
            hold_v_reg      <= 1'b0;
            out_v_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    anr_pkg::REG_OWN_MAC:  own_mac_reg <= cfg_data;
                    anr_pkg::REG_OWN_IP:   own_ip_reg  <= cfg_data[anr_pkg::IP_W-1:0];
                    anr_pkg::REG_LIFETIME: life_reg    <= cfg_data[anr_pkg::MS_W-1:0];
                    anr_pkg::REG_HOLDOFF:  hold_ms_reg <= cfg_data[anr_pkg::MS_W-1:0];
                    default:               own_mac_reg <= own_mac_reg;
                endcase
            end
            now_reg         <= now_next;
            cache_valid_reg <= cache_valid_next;
            hold_valid_reg  <= hold_valid_next;
            idx_reg         <= idx_next;
            jdx_reg         <= jdx_next;
            count_reg       <= count_next;
            c_hit_v_reg     <= c_hit_v_next;
            c_free_v_reg    <= c_free_v_next;
            c_old_v_reg     <= c_old_v_next;
            h_hit_v_reg     <= h_hit_v_next;
            h_free_v_reg    <= h_free_v_next;
            h_old_v_reg     <= h_old_v_next;
            hold_v_reg      <= hold_v_next;
            out_v_reg       <= out_v_next;
        end
    end

    // payload registers and memories
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
            item_reg <= item;
        c_hit_idx_reg  <= c_hit_idx_next;
        c_free_idx_reg <= c_free_idx_next;
        c_old_idx_reg  <= c_old_idx_next;
        c_old_age_reg  <= c_old_age_next;
        c_hit_mac_reg  <= c_hit_mac_next;
        h_free_idx_reg <= h_free_idx_next;
        h_old_idx_reg  <= h_old_idx_next;
        h_old_age_reg  <= h_old_age_next;
        hold_res_reg   <= hold_res_next;
        out_reg        <= out_next;

        cache_rd_reg <= cache_mem[c_a];
        if (ctl.cache_write)
        begin
            cache_mem[c_slot].ip    <= item_reg.sender_ip;
            cache_mem[c_slot].mac   <= item_reg.sender_mac;
            cache_mem[c_slot].stamp <= now_reg;
        end

        hold_rd_reg <= hold_mem[h_a];
        if (ctl.hold_write)
        begin
            hold_mem[h_slot].ip    <= item_reg.hop_ip;
            hold_mem[h_slot].stamp <= now_reg;
        end

        pend_rd_reg <= pend_mem[idx_reg[PAW-1:0]];
        if (p_we)
            pend_mem[p_wa] <= p_wd;
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;
endmodule
`default_nettype wire

[rtl/arp_neighbor_resolver.sv]
// Top level of the ARP neighbour resolver: controller plus datapath.
// Depends on anr_pkg, anr_ctrl, anr_datapath and the assertion macro header.
`default_nettype none
`include "arp_neighbor_resolver_defines.svh"
// ARP neighbour resolver. Pulse start while busy is low to hand over one
// command beat (send, receive or tick); busy stays high until every result
// of that beat but the last has gone out. Results appear one per strobe of
// result_valid and must be taken in that cycle: the block cannot be stalled,
// so the receiver has to sink one beat per clock. result.last marks the
// final result of a command; a command with no results gives no strobe.
// The cache and holdoff tables are walked together, entry by entry over
// max(CACHE_ENTRIES, HOLDOFF_ENTRIES) in the scan read and compare states,
// because each table sits in a single-read-port memory with a registered
// read. A send then passes the result state and, on a miss, the request
// state; a tick goes on to flush; an ARP receive adds the learn state and
// a pending-queue compaction pass over the queued datagrams. Other receives
// go from dispatch straight to flush. The last result is on the ports in
// the first cycle that busy is low. Only an ARP from a sender whose address
// is queued can resolve queued datagrams, so the compaction pass compares
// each entry with the sender's IP. Config writes are taken any time but
// must only be issued while idle. No clearing pass after reset.
module arp_neighbor_resolver #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int HOLDOFF_ENTRIES = 16,
    parameter int PENDING_DEPTH   = 32
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  anr_pkg::in_item_t             item,
    output logic                          result_valid,
    output anr_pkg::out_item_t            result,
    input  wire                           cfg_we,
    input  wire [anr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [anr_pkg::CFG_DATA_W-1:0] cfg_data
);
    anr_pkg::ctl_cmd_t   ctl;
    anr_pkg::dp_status_t st;

    anr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .ctl   (ctl)
    );

    anr_datapath #(
        .C (CACHE_ENTRIES),
        .H (HOLDOFF_ENTRIES),
        .P (PENDING_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .st           (st),
        .result_valid (result_valid),
        .result       (result)
    );

    // accepted beat always moves the sequencer out of idle
    `ANR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // the final result only leaves once the command has finished
    `ANR_ASSERT(a_last_idle, result_valid && result.last, !busy)
    // never enqueue into a full pending queue
    `ANR_ASSERT(a_no_overfill, ctl.queue_push, !st.queue_full)
endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the ARP neighbour resolver (arp_neighbor_resolver).
// Depends on anr_pkg and the RTL; a built-in predictor checks every result beat in order.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int NCACHE = 16;
    localparam int NHOLD  = 16;
    localparam int NPEND  = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    anr_pkg::in_item_t              item = '0;
    logic                           result_valid;
    anr_pkg::out_item_t             result;
    logic                           cfg_we = 1'b0;
    logic [anr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [anr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    arp_neighbor_resolver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state: our own copy of the block's tables and registers
    logic [anr_pkg::MAC_W-1:0]    my_mac;
    logic [anr_pkg::IP_W-1:0]     my_ip;
    logic [anr_pkg::MS_W-1:0]     lifetime_ms;
    logic [anr_pkg::MS_W-1:0]     holdoff_ms;
    bit                           arp_valid [NCACHE];
    logic [anr_pkg::IP_W-1:0]     arp_ip    [NCACHE];
    logic [anr_pkg::MAC_W-1:0]    arp_mac   [NCACHE];
    logic [anr_pkg::TIME_W-1:0]   arp_stamp [NCACHE];
    bit                           req_valid [NHOLD];
    logic [anr_pkg::IP_W-1:0]     req_ip    [NHOLD];
    logic [anr_pkg::TIME_W-1:0]   req_stamp [NHOLD];
    logic [anr_pkg::IP_W-1:0]     wait_ip     [NPEND];
    logic [anr_pkg::HANDLE_W-1:0] wait_handle [NPEND];
    int                           wait_count;
    logic [anr_pkg::TIME_W-1:0]   clock_ms;

    anr_pkg::out_item_t expected_beats [$];
    bit        failed = 1'b0;
    int        cycle_count = 0;

    // Address pool so that random traffic keeps hitting the same neighbours
    logic [anr_pkg::IP_W-1:0]  pool_ip  [8];
    logic [anr_pkg::MAC_W-1:0] pool_mac [8];

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    function automatic int cache_lookup(logic [anr_pkg::IP_W-1:0] ip);
        for (int i = 0; i < NCACHE; i++)
            if (arp_valid[i] && arp_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic int holdoff_lookup(logic [anr_pkg::IP_W-1:0] ip);
        for (int i = 0; i < NHOLD; i++)
            if (req_valid[i] && req_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // First free slot, else the oldest one (lowest index on equal age)
    function automatic int free_or_oldest(bit v [16], logic [anr_pkg::TIME_W-1:0] s [16]);
        int best;
        logic [anr_pkg::TIME_W-1:0] best_age;
        logic [anr_pkg::TIME_W-1:0] a;
        best = 0;
        best_age = '0;
        for (int i = 0; i < 16; i++)
            if (!v[i])
                return i;
        for (int i = 0; i < 16; i++)
        begin
            a = clock_ms - s[i];
            if (i == 0 || a > best_age)
            begin
                best_age = a;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic void add_beat(anr_pkg::kind_t k, logic [anr_pkg::MAC_W-1:0] mac,
                                     logic [anr_pkg::IP_W-1:0] ip,
                                     logic [anr_pkg::HANDLE_W-1:0] h);
        anr_pkg::out_item_t b;
        b.kind = k;
        b.dst_mac = mac;
        b.arp_target_ip = ip;
        b.handle = h;
        b.last = 1'b0;
        expected_beats.push_back(b);
    endfunction

    // Works out the result beats of one accepted command and updates the tables
    function automatic void resolve_beats(anr_pkg::in_item_t it);
        int n_prior;
        int c;
        int s;
        int j;
        n_prior = expected_beats.size();
        if (it.cmd == anr_pkg::CMD_SEND)
        begin
            c = cache_lookup(it.hop_ip);
            if (c >= 0)
                add_beat(anr_pkg::KIND_IPV4, arp_mac[c], '0, it.datagram_handle);
            else
            begin
                if (wait_count < NPEND)
                begin
                    wait_ip[wait_count] = it.hop_ip;
                    wait_handle[wait_count] = it.datagram_handle;
                    wait_count++;
                end
                else
                    add_beat(anr_pkg::KIND_DROP, '0, '0, it.datagram_handle);
                if (holdoff_lookup(it.hop_ip) < 0)
                begin
                    s = free_or_oldest(req_valid, req_stamp);
                    add_beat(anr_pkg::KIND_ARP_REQ, anr_pkg::BCAST_MAC, it.hop_ip, '0);
                    req_valid[s] = 1'b1;
                    req_ip[s] = it.hop_ip;
                    req_stamp[s] = clock_ms;
                end
            end
        end
        else if (it.cmd == anr_pkg::CMD_RECV)
        begin
            if ((it.frame_dst_mac == my_mac || it.frame_dst_mac == anr_pkg::BCAST_MAC)
                && it.parse_ok)
            begin
                if (it.frame_type == anr_pkg::FT_IPV4)
                    add_beat(anr_pkg::KIND_DELIVER, '0, '0, it.datagram_handle);
                else if (it.frame_type == anr_pkg::FT_ARP)
                begin
                    s = cache_lookup(it.sender_ip);
                    if (s < 0)
                        s = free_or_oldest(arp_valid, arp_stamp);
                    arp_valid[s] = 1'b1;
                    arp_ip[s] = it.sender_ip;
                    arp_mac[s] = it.sender_mac;
                    arp_stamp[s] = clock_ms;
                    if (it.arp_opcode == anr_pkg::ARP_OP_REQUEST && it.target_ip == my_ip)
                        add_beat(anr_pkg::KIND_ARP_REPLY, it.sender_mac, it.sender_ip, '0);
                    // compact the queue, releasing what now resolves in order
                    j = 0;
                    for (int i = 0; i < wait_count; i++)
                    begin
                        c = cache_lookup(wait_ip[i]);
                        if (c >= 0)
                            add_beat(anr_pkg::KIND_IPV4, arp_mac[c], '0, wait_handle[i]);
                        else
                        begin
                            wait_ip[j] = wait_ip[i];
                            wait_handle[j] = wait_handle[i];
                            j++;
                        end
                    end
                    wait_count = j;
                end
            end
        end
        else if (it.cmd == anr_pkg::CMD_TICK)
        begin
            clock_ms = clock_ms + it.elapsed_ms;
            for (int i = 0; i < NCACHE; i++)
                if (arp_valid[i] && (clock_ms - arp_stamp[i]) >= lifetime_ms)
                    arp_valid[i] = 1'b0;
            for (int i = 0; i < NHOLD; i++)
                if (req_valid[i] && (clock_ms - req_stamp[i]) >= holdoff_ms)
                    req_valid[i] = 1'b0;
        end
        if (expected_beats.size() > n_prior)
            expected_beats[expected_beats.size()-1].last = 1'b1;
    endfunction

    // Result checker: the receiver cannot stall, so every strobe is a beat
    always @(posedge clk)
    begin
        anr_pkg::out_item_t want;
        if (rst_n && result_valid)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %p", $time, result);
                failed = 1'b1;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (result.kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, result.kind);
                    failed = 1'b1;
                end
                if (result.dst_mac !== want.dst_mac)
                begin
                    $display("%0t: dst_mac expected %h actual %h", $time,
                             want.dst_mac, result.dst_mac);
                    failed = 1'b1;
                end
                if (result.arp_target_ip !== want.arp_target_ip)
                begin
                    $display("%0t: arp_target_ip expected %h actual %h", $time,
                             want.arp_target_ip, result.arp_target_ip);
                    failed = 1'b1;
                end
                if (result.handle !== want.handle)
                begin
                    $display("%0t: handle expected %h actual %h", $time,
                             want.handle, result.handle);
                    failed = 1'b1;
                end
                if (result.last !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, result.last);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Random gap before a beat: mostly none or short, now and then long
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 9);
        if (n < 5)
            n = 0;
        else if (n < 9)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 30);
        repeat (n) @(negedge clk);
    endtask

    // Offer one command beat and hold it until the block takes it
    task automatic send_beat(anr_pkg::in_item_t it);
        idle_gap();
        @(negedge clk);
        item <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        resolve_beats(it);
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Let the block drain; a command with no results may still be running
    task automatic wait_quiet();
        repeat (3) @(posedge clk);
        while (expected_beats.size() != 0 || busy)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    task automatic write_reg(logic [anr_pkg::CFG_IDX_W-1:0] idx,
                             logic [anr_pkg::CFG_DATA_W-1:0] val);
        wait_quiet();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            anr_pkg::REG_OWN_MAC:  my_mac = val[anr_pkg::MAC_W-1:0];
            anr_pkg::REG_OWN_IP:   my_ip = val[anr_pkg::IP_W-1:0];
            anr_pkg::REG_LIFETIME: lifetime_ms = val[anr_pkg::MS_W-1:0];
            anr_pkg::REG_HOLDOFF:  holdoff_ms = val[anr_pkg::MS_W-1:0];
            default: ;
        endcase
    endtask

    // Item builders; unrelated fields carry random noise
    function automatic anr_pkg::in_item_t noise_item();
        anr_pkg::in_item_t it;
        logic [255:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom()};
        it = raw[$bits(anr_pkg::in_item_t)-1:0];
        return it;
    endfunction

    function automatic anr_pkg::in_item_t send_item(logic [anr_pkg::IP_W-1:0] hop,
                                                    logic [anr_pkg::HANDLE_W-1:0] h);
        anr_pkg::in_item_t it;
        it = noise_item();
        it.cmd = anr_pkg::CMD_SEND;
        it.hop_ip = hop;
        it.datagram_handle = h;
        return it;
    endfunction

    function automatic anr_pkg::in_item_t arp_item(logic [anr_pkg::MAC_W-1:0] dst,
                                                   logic [1:0] op,
                                                   logic [anr_pkg::IP_W-1:0] sip,
                                                   logic [anr_pkg::MAC_W-1:0] smac,
                                                   logic [anr_pkg::IP_W-1:0] tip);
        anr_pkg::in_item_t it;
        it = noise_item();
        it.cmd = anr_pkg::CMD_RECV;
        it.frame_dst_mac = dst;
        it.frame_type = anr_pkg::FT_ARP;
        it.parse_ok = 1'b1;
        it.arp_opcode = op;
        it.sender_ip = sip;
        it.sender_mac = smac;
        it.target_ip = tip;
        return it;
    endfunction

    function automatic anr_pkg::in_item_t ipv4_item(logic [anr_pkg::MAC_W-1:0] dst,
                                                    logic ok, logic [1:0] ft,
                                                    logic [anr_pkg::HANDLE_W-1:0] h);
        anr_pkg::in_item_t it;
        it = noise_item();
        it.cmd = anr_pkg::CMD_RECV;
        it.frame_dst_mac = dst;
        it.frame_type = ft;
        it.parse_ok = ok;
        it.datagram_handle = h;
        return it;
    endfunction

    function automatic anr_pkg::in_item_t tick_item(logic [anr_pkg::MS_W-1:0] ms);
        anr_pkg::in_item_t it;
        it = noise_item();
        it.cmd = anr_pkg::CMD_TICK;
        it.elapsed_ms = ms;
        return it;
    endfunction

    // Resolution round trip, reply handling, frame filtering, unused command
    task automatic test_directed();
        anr_pkg::in_item_t it;
        write_reg(anr_pkg::REG_OWN_MAC, 48'h02_00_00_00_00_01);
        write_reg(anr_pkg::REG_OWN_IP, 48'h0A00_0001);
        send_beat(send_item(32'h0A00_0002, 8'h00));     // miss: queued, request out
        send_beat(send_item(32'h0A00_0002, 8'hFF));     // held off: queued only
        send_beat(arp_item(anr_pkg::BCAST_MAC, anr_pkg::ARP_OP_REPLY, 32'h0A00_0002,
                           48'hFFFF_FFFF_FFFE, 32'h0));
        send_beat(send_item(32'h0A00_0002, 8'h5A));     // hit
        send_beat(ipv4_item(my_mac, 1'b1, anr_pkg::FT_IPV4, 8'hA5));
        send_beat(ipv4_item(anr_pkg::BCAST_MAC, 1'b1, anr_pkg::FT_IPV4, 8'hFF));
        send_beat(ipv4_item(48'h0, 1'b1, anr_pkg::FT_IPV4, 8'h01));   // not for us
        send_beat(ipv4_item(my_mac, 1'b0, anr_pkg::FT_IPV4, 8'h02));  // failed parse
        send_beat(ipv4_item(my_mac, 1'b1, anr_pkg::FT_OTHER, 8'h03)); // other ethertype
        send_beat(ipv4_item(my_mac, 1'b1, anr_pkg::FT_UNDEF, 8'h04));
        send_beat(arp_item(my_mac, anr_pkg::ARP_OP_REQUEST, 32'hFFFF_FFFF, 48'h0, my_ip));
        send_beat(arp_item(my_mac, anr_pkg::ARP_OP_REQUEST, 32'h0, 48'h1234_5678_9ABC,
                           32'h0A00_0009));
        send_beat(arp_item(my_mac, anr_pkg::ARP_OP_OTHER, 32'h0A00_0003, 48'hAB, my_ip));
        send_beat(arp_item(my_mac, anr_pkg::ARP_OP_UNDEF, 32'h0A00_0004, 48'hCD, my_ip));
        send_beat(send_item(32'h0A00_0003, 8'h10));
        it = noise_item();
        it.cmd = anr_pkg::CMD_NONE;
        send_beat(it);
        send_beat(tick_item(16'd0));
        send_beat(tick_item(16'hFFFF));                 // everything expires
        send_beat(send_item(32'h0A00_0003, 8'h11));
    endtask

    // Queue overflow: drops still followed by the request check
    task automatic test_queue_full();
        for (int i = 0; i < NPEND + 3; i++)
            send_beat(send_item(32'hC0A8_0000 + (i % 20), i[7:0]));
        send_beat(arp_item(my_mac, anr_pkg::ARP_OP_REPLY, 32'hC0A8_0005, rand48(), 32'h0));
        send_beat(send_item(32'hC0A8_0100, 8'hEE));
        send_beat(arp_item(anr_pkg::BCAST_MAC, anr_pkg::ARP_OP_REPLY, 32'hC0A8_0000,
                           rand48(), 32'h0));
    endtask

    // More neighbours than table slots: oldest entry goes
    task automatic test_table_full();
        for (int i = 0; i < NCACHE + 2; i++)
        begin
            send_beat(arp_item(my_mac, anr_pkg::ARP_OP_REPLY, 32'h0B00_0000 + i,
                               rand48(), 32'h0));
            if (i % 4 == 3)
                send_beat(tick_item(16'd1));
        end
        for (int i = 0; i < NHOLD + 2; i++)
        begin
            send_beat(send_item(32'h0C00_0000 + i, i[7:0]));
            if (i % 4 == 3)
                send_beat(tick_item(16'd1));
        end
        send_beat(send_item(32'h0B00_0000, 8'h01));
        send_beat(send_item(32'h0B00_0011, 8'h02));
        send_beat(send_item(32'h0C00_0000, 8'h03));
    endtask

    // Mostly well-formed traffic over a small address pool, some noise
    task automatic test_random(int count);
        anr_pkg::in_item_t it;
        int p;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(0, 7);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    it = send_item(pool_ip[p], 8'($urandom()));
                8, 9, 10, 11, 12, 13:
                    it = arp_item($urandom_range(0, 1) ? my_mac : anr_pkg::BCAST_MAC,
                                  2'($urandom_range(0, 3)), pool_ip[p], pool_mac[p],
                                  $urandom_range(0, 1) ? my_ip : pool_ip[$urandom_range(0, 7)]);
                14, 15:
                    it = ipv4_item($urandom_range(0, 1) ? my_mac : anr_pkg::BCAST_MAC, 1'b1,
                                   anr_pkg::FT_IPV4, 8'($urandom()));
                16, 17:
                    it = tick_item(16'($urandom_range(0, 3) == 0 ? $urandom()
                                                                 : $urandom_range(0, 400)));
                default:
                    it = noise_item();
            endcase
            send_beat(it);
        end
    endtask

    task automatic new_pool();
        for (int i = 0; i < 8; i++)
        begin
            pool_ip[i] = $urandom();
            pool_mac[i] = rand48();
        end
        pool_ip[0] = my_ip;
    endtask

    initial
    begin
        my_mac = '0;
        my_ip = '0;
        lifetime_ms = anr_pkg::LIFETIME_RESET;
        holdoff_ms = anr_pkg::HOLDOFF_RESET;
        for (int i = 0; i < NCACHE; i++)
            arp_valid[i] = 1'b0;
        for (int i = 0; i < NHOLD; i++)
            req_valid[i] = 1'b0;
        wait_count = 0;
        clock_ms = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values first: own MAC and IP are zero here
        send_beat(arp_item(48'h0, anr_pkg::ARP_OP_REQUEST, 32'h0101_0101, 48'h11, 32'h0));
        test_directed();
        test_queue_full();
        test_table_full();

        // short lifetimes: entries expire on almost every tick
        write_reg(anr_pkg::REG_LIFETIME, 48'd1);
        write_reg(anr_pkg::REG_HOLDOFF, 48'd1);
        new_pool();
        test_random(15);

        write_reg(anr_pkg::REG_LIFETIME, 48'hFFFF);
        write_reg(anr_pkg::REG_HOLDOFF, 48'hFFFF);
        write_reg(anr_pkg::REG_OWN_MAC, {16'h0, $urandom()});
        write_reg(anr_pkg::REG_OWN_IP, {16'h0, $urandom()});
        new_pool();
        test_random(15);

        write_reg(anr_pkg::REG_LIFETIME, 48'd700);
        write_reg(anr_pkg::REG_HOLDOFF, 48'd150);
        write_reg(anr_pkg::REG_OWN_MAC, anr_pkg::BCAST_MAC);
        write_reg(anr_pkg::REG_OWN_IP, 48'hFFFF_FFFF);
        new_pool();
        test_random(15);

        wait_quiet();
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
